// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Self-contained; the including scope must provide signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define PTIS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define PTIS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define PTIS_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ptis_pkg.sv =====
// Package for the Poisson table inversion sampler: widths, constants, types.
// No dependencies; used by the term unit, the top level and the checker.
package ptis_pkg;

   // Fixed-point formats
   localparam int PROB_BITS  = 32;   // probabilities and U, 0.PROB_BITS
   localparam int THETA_W    = 32;   // theta, unsigned Q4.28
   localparam int THETA_FRAC = 28;
   localparam int MODE_W     = THETA_W - THETA_FRAC;
   localparam int COUNT_W    = 6;

   // Threshold for starting the search near the mode: floor(0.458 * 2^PROB_BITS)
   localparam logic [PROB_BITS-1:0] HIGH_THRESH =
      PROB_BITS'((64'd458 << PROB_BITS) / 64'd1000);

   // Register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_PARAM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_PROB  = 2'd1;

   localparam logic [THETA_W-1:0]   RATE_RESET = 32'd268435456;
   localparam logic [PROB_BITS-1:0] ZERO_RESET = 32'd1580030169;

   // Term unit: product term*theta >> THETA_FRAC, then divided by k
   localparam int MULT_W        = PROB_BITS + THETA_W;
   localparam int PROD_W        = MULT_W - THETA_FRAC;
   localparam int DIV_DIGIT     = 8;   // quotient bits per divider cycle
   localparam int DIV_STEPS     = (PROD_W + DIV_DIGIT - 1) / DIV_DIGIT;
   localparam int QUOT_W        = DIV_STEPS * DIV_DIGIT;
   localparam int DIV_CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   typedef logic [PROB_BITS-1:0] prob_type;

   typedef struct packed {
      logic                 start;
      logic [PROB_BITS-1:0] term;
      logic [THETA_W-1:0]   theta;
      logic [COUNT_W-1:0]   k;
   } term_req_type;

   typedef struct packed {
      logic                 done;
      logic [PROB_BITS-1:0] value;
   } term_rsp_type;

endpackage

// ===== rtl/ptis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 35
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/ptis_term_unit.sv =====
// Shared term unit: next = sat(floor(term * theta / (k * 2^28))).
// Registers the product, then runs a radix-256 divider by the 6-bit k. Uses ptis_pkg.
module ptis_term_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  ptis_pkg::term_req_type req,
   output ptis_pkg::term_rsp_type rsp
);

   typedef enum logic [3:0] {
      TU_IDLE = 4'b0001,
      TU_LOAD = 4'b0010,
      TU_DIV  = 4'b0100,
      TU_DONE = 4'b1000
   } tu_state_type;

   tu_state_type                      state_ff, state_in;
   logic [ptis_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [ptis_pkg::COUNT_W-1:0]      k_ff, k_in;
   logic [ptis_pkg::QUOT_W-1:0]       quot_ff, quot_in;
   logic [ptis_pkg::COUNT_W-1:0]      rem_ff, rem_in;
   logic [ptis_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ptis_pkg::MULT_W-1:0]       full_prod;
   logic [ptis_pkg::QUOT_W-1:0]       quot_step;
   logic [ptis_pkg::COUNT_W-1:0]      rem_step;

   assign full_prod = ptis_pkg::MULT_W'(req.term) * ptis_pkg::MULT_W'(req.theta);

   // DIV_DIGIT restoring steps; remainder stays below k
   always_comb begin
      logic [ptis_pkg::COUNT_W:0]   trial;
      logic [ptis_pkg::COUNT_W-1:0] r;
      logic [ptis_pkg::QUOT_W-1:0]  q;
      r = rem_ff;
      q = quot_ff;
      for (int i = 0; i < ptis_pkg::DIV_DIGIT; i++) begin
         trial = {r, q[ptis_pkg::QUOT_W-1]};
         q     = {q[ptis_pkg::QUOT_W-2:0], 1'b0};
         if (trial >= {1'b0, k_ff}) begin
            trial = trial - {1'b0, k_ff};
            q[0]  = 1'b1;
         end
         r = trial[ptis_pkg::COUNT_W-1:0];
      end
      quot_step = q;
      rem_step  = r;
   end

   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      k_in     = k_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         TU_IDLE: begin
            if (req.start) begin
               prod_in  = full_prod[ptis_pkg::MULT_W-1:ptis_pkg::THETA_FRAC];
               k_in     = req.k;
               state_in = TU_LOAD;
            end
         end
         TU_LOAD: begin
            quot_in  = ptis_pkg::QUOT_W'(prod_ff);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = TU_DIV;
         end
         TU_DIV: begin
            quot_in = quot_step;
            rem_in  = rem_step;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == ptis_pkg::DIV_CNT_W'(ptis_pkg::DIV_STEPS - 1)) begin
               state_in = TU_DONE;
            end
         end
         TU_DONE: begin
            state_in = TU_IDLE;
         end
         default: begin
            state_in = TU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TU_IDLE;
      end else begin
         state_ff <= state_in;
      end
      prod_ff <= prod_in;
      k_ff    <= k_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign rsp.done  = (state_ff == TU_DONE);
   assign rsp.value = (|quot_ff[ptis_pkg::QUOT_W-1:ptis_pkg::PROB_BITS]) ?
                      '1 : quot_ff[ptis_pkg::PROB_BITS-1:0];

endmodule

// ===== rtl/poisson_table_inversion_sampler.sv =====
// Poisson sampler by table inversion: top level with the sequencer and table state.
// Depends on ptis_pkg, ptis_ram and ptis_term_unit.
// Usage
//  - req_*: one transaction carries a uniform 0.32 fraction U. req_stall is high
//    while an item is in work; the block takes one item at a time.
//  - rsp_*: zero or one transaction per item, carrying the Poisson count.
//    U above the last entry of a full table gives no transaction; draw again.
//  - csr_*: register writes (index 0 theta Q4.28, index 1 exp(-theta)), taken
//    only while idle with req_valid low. A write to index 0 or 1 drops the cached table.
// Flow from acceptance to rsp_valid
//  - U <= exp(-theta): straight to ST_FINISH, which loads the output register.
//  - Hit in the cached table: the search walks entries from its start (RAM read
//    pipelined with the compare), then ST_FINISH.
//  - Each entry still to build runs on the shared term unit (multiply, load,
//    DIV_STEPS radix-256 divide steps, accumulate), up to TABLE_SIZE entries.
//  - The next item can be accepted in the cycle after the result is loaded.
// Reset (synchronous) restores the register defaults, empties the table and
// drops any pending result. While rsp_stall is high a finished result waits in
// the output register; a new item can be accepted, but its result is held in
// the sequencer until the output register frees up.
module poisson_table_inversion_sampler #(
   parameter int TABLE_SIZE = 35
) (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ptis_pkg::PROB_BITS-1:0]    req_uniform_sample,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ptis_pkg::COUNT_W-1:0]      rsp_count,
   // configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ptis_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_data
);

   localparam int ADDR_W = $clog2(TABLE_SIZE);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,   // walk cached entries, one per cycle
      ST_BUILD  = 5'b00100,   // launch the term unit
      ST_WAIT   = 5'b01000,   // wait for the term, accumulate, store
      ST_FINISH = 5'b10000    // hand result to the output register
   } state_type;

   state_type                        state_ff, state_in;
   ptis_pkg::prob_type               u_ff, u_in;
   logic [ptis_pkg::COUNT_W-1:0]     k_ff, k_in;
   logic [ptis_pkg::COUNT_W-1:0]     res_ff, res_in;
   logic [ptis_pkg::COUNT_W-1:0]     level_ff, level_in;
   ptis_pkg::prob_type               last_term_ff, last_term_in;
   ptis_pkg::prob_type               running_sum_ff, running_sum_in;
   logic [ptis_pkg::THETA_W-1:0]     rate_ff, rate_in;
   ptis_pkg::prob_type               zero_ff, zero_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ptis_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                             ram_we, ram_re;
   logic [ADDR_W-1:0]                ram_waddr, ram_raddr;
   ptis_pkg::prob_type               ram_wdata, ram_rdata;

   ptis_pkg::term_req_type           term_req;
   ptis_pkg::term_rsp_type           term_rsp;

   logic [ptis_pkg::MODE_W-1:0]      mode_w;
   logic [ptis_pkg::COUNT_W-1:0]     start_w, start_m1, k_m1;
   logic [ptis_pkg::PROB_BITS:0]     sum_wide;
   ptis_pkg::prob_type               sum_sat;
   logic                             table_full, k_last;

   // Cumulative table: entry K-1 holds F(K)
   ptis_ram #(
      .WIDTH (ptis_pkg::PROB_BITS),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ptis_term_unit u_term (
      .clock (clock),
      .reset (reset),
      .req   (term_req),
      .rsp   (term_rsp)
   );

   assign term_req.start = (state_ff == ST_BUILD);
   assign term_req.term  = last_term_ff;
   assign term_req.theta = rate_ff;
   assign term_req.k     = k_ff;

   // mode = max(1, floor theta); search start for large U = min(level, mode)
   assign mode_w  = (rate_ff[ptis_pkg::THETA_W-1:ptis_pkg::THETA_FRAC] == '0) ?
                    ptis_pkg::MODE_W'(1) :
                    rate_ff[ptis_pkg::THETA_W-1:ptis_pkg::THETA_FRAC];
   assign start_w = (req_uniform_sample > ptis_pkg::HIGH_THRESH) ?
                    ((level_ff < ptis_pkg::COUNT_W'(mode_w)) ?
                     level_ff : ptis_pkg::COUNT_W'(mode_w)) :
                    ptis_pkg::COUNT_W'(1);
   assign start_m1 = start_w - ptis_pkg::COUNT_W'(1);
   assign k_m1     = k_ff - ptis_pkg::COUNT_W'(1);

   // saturating running sum
   assign sum_wide = {1'b0, running_sum_ff} + {1'b0, term_rsp.value};
   assign sum_sat  = sum_wide[ptis_pkg::PROB_BITS] ? '1 :
                     sum_wide[ptis_pkg::PROB_BITS-1:0];

   assign table_full = (level_ff == ptis_pkg::COUNT_W'(TABLE_SIZE));
   assign k_last     = (k_ff == ptis_pkg::COUNT_W'(TABLE_SIZE));

   always_comb begin
      state_in       = state_ff;
      u_in           = u_ff;
      k_in           = k_ff;
      res_in         = res_ff;
      level_in       = level_ff;
      last_term_in   = last_term_ff;
      running_sum_in = running_sum_ff;
      rate_in        = rate_ff;
      zero_in        = zero_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_count_in   = rsp_count_ff;
      ram_we         = 1'b0;
      ram_waddr      = k_m1[ADDR_W-1:0];
      ram_wdata      = sum_sat;
      ram_re         = 1'b0;
      ram_raddr      = k_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               u_in = req_uniform_sample;
               if (req_uniform_sample <= zero_ff) begin
                  res_in   = '0;
                  state_in = ST_FINISH;
               end else if (level_ff != '0) begin
                  k_in      = start_w;
                  ram_re    = 1'b1;
                  ram_raddr = start_m1[ADDR_W-1:0];
                  state_in  = ST_SEARCH;
               end else begin
                  k_in     = ptis_pkg::COUNT_W'(1);
                  state_in = ST_BUILD;
               end
            end
         end
         ST_SEARCH: begin
            // ram_rdata holds F(k_ff)
            if (u_ff <= ram_rdata) begin
               res_in   = k_ff;
               state_in = ST_FINISH;
            end else if (k_ff == level_ff) begin
               if (table_full) begin
                  state_in = ST_IDLE;   // U beyond the table: no result
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_BUILD;
               end
            end else begin
               ram_re = 1'b1;           // address k_ff holds F(k_ff + 1)
               k_in   = k_ff + 1'b1;
            end
         end
         ST_BUILD: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (term_rsp.done) begin
               ram_we         = 1'b1;
               last_term_in   = term_rsp.value;
               running_sum_in = sum_sat;
               level_in       = k_ff;
               if (u_ff <= sum_sat) begin
                  res_in   = k_ff;
                  state_in = ST_FINISH;
               end else if (k_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_BUILD;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register write; a write to index 0 or 1 drops the cached table
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ptis_pkg::CSR_RATE_PARAM: begin
               rate_in        = csr_data[ptis_pkg::THETA_W-1:0];
               level_in       = '0;
               last_term_in   = zero_ff;
               running_sum_in = zero_ff;
            end
            ptis_pkg::CSR_ZERO_PROB: begin
               zero_in        = csr_data[ptis_pkg::PROB_BITS-1:0];
               level_in       = '0;
               last_term_in   = csr_data[ptis_pkg::PROB_BITS-1:0];
               running_sum_in = csr_data[ptis_pkg::PROB_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         level_ff       <= '0;
         last_term_ff   <= ptis_pkg::ZERO_RESET;
         running_sum_ff <= ptis_pkg::ZERO_RESET;
         rate_ff        <= ptis_pkg::RATE_RESET;
         zero_ff        <= ptis_pkg::ZERO_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         level_ff       <= level_in;
         last_term_ff   <= last_term_in;
         running_sum_ff <= running_sum_in;
         rate_ff        <= rate_in;
         zero_ff        <= zero_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      u_ff         <= u_in;
      k_ff         <= k_in;
      res_ff       <= res_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   // a write never lands in the same cycle as a new input transaction
   assign csr_ready = (state_ff == ST_IDLE) && !req_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;

endmodule

// ===== rtl/ptis_checker.sv =====
// Port-level checker for the Poisson table inversion sampler, bound to the top.
// Depends on ptis_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptis_checker #(
   parameter int TABLE_SIZE = 35
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [ptis_pkg::COUNT_W-1:0] rsp_count
);

   // stalled result holds
   `PTIS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_count), "stalled result changed")

   // a count never exceeds the table size
   `PTIS_ASSERT_SAME(a_count_range, rsp_valid, rsp_count <= ptis_pkg::COUNT_W'(TABLE_SIZE), "count out of range")

   // one item in work at a time
   `PTIS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted two items back to back")

   // reset drops any pending result
   `PTIS_ASSERT_RESET(a_reset_clears, reset, !rsp_valid, "result valid after reset")

endmodule

bind poisson_table_inversion_sampler ptis_checker #(
   .TABLE_SIZE (TABLE_SIZE)
) u_ptis_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_count (rsp_count)
);
